// ----- src/aces_filmic_tone_map_core_assert.svh -----
// Assertion macros for the ACES filmic tone map core.
`ifndef ACES_FILMIC_TONE_MAP_CORE_ASSERT_SVH
`define ACES_FILMIC_TONE_MAP_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off while in reset.
`define AFM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("afm check failed");

// Next-cycle implication.
`define AFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("afm check failed");

`endif

// ----- src/afm_pkg.sv -----
// Shared widths and constants for the ACES filmic tone map core.
package afm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CH_W      = 24;            // input channel width
  localparam int OUT_W     = 8;             // output byte width
  localparam int XW        = FRAC_BITS + 3; // values below 8.0 need this many bits
  localparam int SQ_W      = 2 * XW;
  localparam int T_W       = XW + 8;        // 251x + 3S
  localparam int WW        = 2 * XW + 9;    // numerator and denominator
  localparam int RW        = WW + 8;        // 255 * numerator
  localparam int DIV_STEPS = OUT_W;
  localparam int POLY_LAT  = 3;
  localparam int LAT       = POLY_LAT + 1 + DIV_STEPS;

  localparam int C_NUM_A = 251;
  localparam int C_NUM_B = 3;
  localparam int C_DEN_A = 243;
  localparam int C_DEN_B = 59;
  localparam int C_DEN_C = 14;

endpackage

// ----- src/afm_poly.sv -----
// Numerator and denominator of the rational curve, three register stages.
module afm_poly (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [afm_pkg::CH_W-1:0]  ch_i,
  output logic [afm_pkg::WW-1:0]    num_o,
  output logic [afm_pkg::WW-1:0]    den_o,
  output logic                      sat_o
);
  import afm_pkg::*;

  logic [XW-1:0]   x1_q, x2_q;
  logic            sat1_q, sat2_q, sat3_q;
  logic [SQ_W-1:0] sq_q;
  logic [T_W-1:0]  t_q;
  logic [WW-1:0]   num_q, den_q;

  logic [T_W-1:0]  t_d;
  logic [WW-1:0]   num_d, den_d;

  assign t_d = T_W'(C_NUM_A) * T_W'(x1_q) + (T_W'(C_NUM_B) << FRAC_BITS);

  // den = 243 x^2 + 59 x S + 14 S^2
  assign num_d = WW'(x2_q) * WW'(t_q);
  assign den_d = WW'(C_DEN_A) * WW'(sq_q)
               + ((WW'(C_DEN_B) * WW'(x2_q)) << FRAC_BITS)
               + (WW'(C_DEN_C) << (2 * FRAC_BITS));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= ch_i[XW-1:0];
      sat1_q <= |ch_i[CH_W-1:XW];
      x2_q   <= x1_q;
      sq_q   <= SQ_W'(x1_q) * SQ_W'(x1_q);
      t_q    <= t_d;
      sat2_q <= sat1_q;
      num_q  <= num_d;
      den_q  <= den_d;
      sat3_q <= sat2_q;
    end
  end

  assign num_o = num_q;
  assign den_o = den_q;
  assign sat_o = sat3_q;

endmodule

// ----- src/afm_div.sv -----
// floor(255 * num / den) by restoring division, one quotient bit per stage.
module afm_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [afm_pkg::WW-1:0]    num_i,
  input  logic [afm_pkg::WW-1:0]    den_i,
  input  logic                      sat_i,
  output logic [afm_pkg::OUT_W-1:0] byte_o
);
  import afm_pkg::*;

  logic [RW-1:0]    r_q   [DIV_STEPS+1];
  logic [OUT_W-1:0] q_q   [DIV_STEPS+1];
  logic             sat_q [DIV_STEPS+1];
  logic [WW-1:0]    d_q   [DIV_STEPS];

  // prep stage: scale numerator, flag f >= 1
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= (RW'(num_i) << 8) - RW'(num_i);
      q_q[0]   <= '0;
      d_q[0]   <= den_i;
      sat_q[0] <= sat_i | (num_i >= den_i);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int B = DIV_STEPS - 1 - k;
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(d_q[k]) << B;
    assign ge = r_q[k] >= sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge ? (r_q[k] - sh) : r_q[k];
        q_q[k+1]   <= q_q[k] | (OUT_W'(ge) << B);
        sat_q[k+1] <= sat_q[k];
      end
    end

    if (k < DIV_STEPS - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          d_q[k+1] <= d_q[k];
        end
      end
    end
  end

  assign byte_o = sat_q[DIV_STEPS] ? {OUT_W{1'b1}} : q_q[DIV_STEPS];

endmodule

// ----- src/aces_filmic_tone_map_core.sv -----
// ACES filmic tone map core, pipelined from input word to output word.
// Throughput one pixel per cycle while the output is not stalled: every channel runs in
// a 12-stage pipeline (3 polynomial stages, 1 prep stage, 8 restoring-division stages).
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// rst_ni (async, active low) clears only the valid bits; data regs are not reset.
module aces_filmic_tone_map_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // [23:0] red_in, [47:24] green_in, [71:48] blue_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
);
  import afm_pkg::*;
  `include "aces_filmic_tone_map_core_assert.svh"

  // global advance: pipeline moves when the last stage is empty or drained
  logic           adv;
  logic [LAT-1:0] vld_q, vld_d;

  assign adv             = !vld_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[LAT-1];
  assign vld_d           = adv ? {vld_q[LAT-2:0], s_axis_tvalid_i} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // three independent channel datapaths
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [WW-1:0] num, den;
    logic          sat;

    afm_poly u_poly (
      .clk_i (clk_i),
      .en_i  (adv),
      .ch_i  (s_axis_tdata_i[c*CH_W +: CH_W]),
      .num_o (num),
      .den_o (den),
      .sat_o (sat)
    );

    afm_div u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (num),
      .den_i  (den),
      .sat_i  (sat),
      .byte_o (m_axis_tdata_o[c*OUT_W +: OUT_W])
    );
  end

  // a frozen pipeline keeps all its valid bits
  `AFM_ASSERT_NEXT(a_hold_valids, !adv, $stable(vld_q))
  // an accepted word occupies the first stage next cycle
  `AFM_ASSERT_NEXT(a_enter, s_axis_tvalid_i && adv, vld_q[0])
  // no word appears from nothing
  `AFM_ASSERT_NEXT(a_no_phantom, adv && !s_axis_tvalid_i, !vld_q[0])
  // the output stage never stalls while it is empty
  `AFM_ASSERT_NOW(a_ready_when_empty, !vld_q[LAT-1], s_axis_tready_o)

endmodule
